>>> src/gim_pkg.sv
// Shared types and constants for the graph isomorphism invariant check.
// Used by gim_adj_ram and graph_isomorphism_invariant_check; depends on nothing.
package gim_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VW           = $clog2(MAX_VERTICES);
    localparam int AW           = VW + 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int EDGE_W       = $clog2(MAX_VERTICES * MAX_VERTICES + 1);

    localparam int CFG_W        = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int ROW_W        = 4;
    localparam int COL_W        = 4;
    localparam int S_DATA_W     = 16;
    localparam int M_DATA_W     = 8;
    localparam int VERDICT_W    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VERTICES_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTICES_SECOND = 1'b1;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_MAYBE     = 3'd0,
        VERDICT_FIRST_NS  = 3'd1,
        VERDICT_SECOND_NS = 3'd2,
        VERDICT_VCOUNT    = 3'd3,
        VERDICT_EDGES     = 3'd4,
        VERDICT_DEGREES   = 3'd5
    } t_verdict;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_ROW,
        ST_GET_ROW,
        ST_SCAN,
        ST_COUNTS,
        ST_DEGREES
    } t_state;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [VW-1:0] col;
        logic          val;
    } t_ram_wr;

endpackage

>>> src/gim_adj_ram.sv
// Adjacency row store: one row bit mask per vertex for both graphs, bit writes.
// One read port with registered data. Depends on gim_pkg.
module gim_adj_ram (
    input  logic                              i_clk,
    input  gim_pkg::t_ram_wr                  i_wr,
    input  logic [gim_pkg::AW-1:0]            i_rd_addr,
    output logic [gim_pkg::MAX_VERTICES-1:0]  o_rd_data
);

    logic [gim_pkg::MAX_VERTICES-1:0] r_mem [2*gim_pkg::MAX_VERTICES];
    logic [gim_pkg::MAX_VERTICES-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr][i_wr.col] <= i_wr.val;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/graph_isomorphism_invariant_check.sv
// A last transfer is stored and starts a check; other transfers are only stored.
// The check walks the stored rows through one registered RAM read port, one row entry a cycle.
// No transfer is taken while a check runs or a verdict waits on the output.
// Reset (synchronous, active low) sets both vertex counts to 16 and clears control state;
// the adjacency store is not cleared.
module graph_isomorphism_invariant_check (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gim_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gim_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gim_pkg::S_DATA_W-1:0]      s_tdata,   // row[3:0], col[7:4], edge_req[8]
    input  logic                              s_tuser,   // graph_sel[0]
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gim_pkg::M_DATA_W-1:0]      m_tdata    // verdict[2:0]
);

    localparam int MAXV = gim_pkg::MAX_VERTICES;
    localparam int VW   = gim_pkg::VW;
    localparam int CW   = gim_pkg::CNT_W;
    localparam int EW   = gim_pkg::EDGE_W;

    localparam logic [gim_pkg::CFG_IDX_W-1:0] REG_SEL_FIRST  = gim_pkg::REG_VERTICES_FIRST;
    localparam logic [gim_pkg::CFG_IDX_W-1:0] REG_SEL_SECOND = gim_pkg::REG_VERTICES_SECOND;

    gim_pkg::t_state   r_state, n_state;
    logic [gim_pkg::CFG_W-1:0] r_nv1, r_nv2;
    logic              r_g, n_g;
    logic [VW-1:0]     r_i, n_i, r_j, n_j;
    logic [MAXV-1:0]   r_row, n_row;
    logic [CW-1:0]     r_deg, n_deg, r_d, n_d;
    logic [CW:0]       r_diff, n_diff;
    logic [EW-1:0]     r_e1, n_e1, r_e2, n_e2;
    logic              r_out_valid, n_out_valid;
    gim_pkg::t_verdict r_verdict, n_verdict;
    logic [CW-1:0]     r_deg1 [MAXV];
    logic [CW-1:0]     r_deg2 [MAXV];

    gim_pkg::t_ram_wr       ram_wr;
    logic [gim_pkg::AW-1:0] rd_addr;
    logic [MAXV-1:0]        rd_data;

    logic                   s_acc;
    logic [gim_pkg::ROW_W-1:0] in_row;
    logic [gim_pkg::COL_W-1:0] in_col;
    logic [CW-1:0]          n1, n2, n_cur;
    logic                   j_end, i_end, mismatch, diag;
    logic [CW-1:0]          deg_row;
    logic                   deg_we;
    logic                   hit1, hit2;
    logic [CW:0]            diff_next;

    function automatic logic [CW-1:0] eff_count(input logic [gim_pkg::CFG_W-1:0] v);
        int vi;
        vi = int'(v);
        if (vi < 1) return CW'(1);
        if (vi > MAXV) return CW'(MAXV);
        return CW'(vi);
    endfunction

    assign in_row  = s_tdata[3:0];
    assign in_col  = s_tdata[7:4];
    assign s_acc   = s_tvalid && s_tready;
    assign n1      = eff_count(r_nv1);
    assign n2      = eff_count(r_nv2);
    assign n_cur   = r_g ? n2 : n1;
    assign j_end   = (CW'(r_j) == n_cur - CW'(1));
    assign i_end   = (CW'(r_i) == n_cur - CW'(1));
    assign mismatch = (r_row[r_j] != rd_data[r_i]);
    assign diag    = rd_data[r_i];
    assign deg_row = r_deg + CW'(r_row[r_j]);
    assign hit1    = (r_deg1[r_i] == r_d);
    assign hit2    = (r_deg2[r_i] == r_d);
    assign diff_next = r_diff + (CW+1)'(hit1) - (CW+1)'(hit2);

    gim_adj_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gim_pkg::ST_IDLE: begin
                if (s_acc && s_tlast) n_state = gim_pkg::ST_RD_ROW;
            end
            gim_pkg::ST_RD_ROW: begin
                n_state = gim_pkg::ST_GET_ROW;
            end
            gim_pkg::ST_GET_ROW: begin
                n_state = diag ? gim_pkg::ST_IDLE : gim_pkg::ST_SCAN;
            end
            gim_pkg::ST_SCAN: begin
                if (mismatch) begin
                    n_state = gim_pkg::ST_IDLE;
                end else if (j_end) begin
                    if (i_end && r_g) n_state = gim_pkg::ST_COUNTS;
                    else              n_state = gim_pkg::ST_RD_ROW;
                end
            end
            gim_pkg::ST_COUNTS: begin
                if (n1 != n2 || r_e1 != r_e2) n_state = gim_pkg::ST_IDLE;
                else                          n_state = gim_pkg::ST_DEGREES;
            end
            gim_pkg::ST_DEGREES: begin
                if (i_end && (diff_next != '0 || r_d == n1)) n_state = gim_pkg::ST_IDLE;
            end
            default: n_state = gim_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_g         = r_g;
        n_i         = r_i;
        n_j         = r_j;
        n_row       = r_row;
        n_deg       = r_deg;
        n_d         = r_d;
        n_diff      = r_diff;
        n_e1        = r_e1;
        n_e2        = r_e2;
        n_out_valid = r_out_valid && !m_tready;
        n_verdict   = r_verdict;
        deg_we      = 1'b0;
        rd_addr     = {r_g, r_i};
        s_tready    = (r_state == gim_pkg::ST_IDLE) && !r_out_valid;

        ram_wr.we   = s_acc && (int'(in_row) < MAXV) && (int'(in_col) < MAXV);
        ram_wr.addr = {s_tuser, VW'(in_row)};
        ram_wr.col  = VW'(in_col);
        ram_wr.val  = s_tdata[8];

        unique case (r_state)
            gim_pkg::ST_IDLE: begin
                if (s_acc && s_tlast) begin
                    n_g  = 1'b0;
                    n_i  = '0;
                    n_e1 = '0;
                    n_e2 = '0;
                end
            end
            gim_pkg::ST_RD_ROW: begin
                rd_addr = {r_g, r_i};
            end
            gim_pkg::ST_GET_ROW: begin
                rd_addr = {r_g, VW'(0)};
                n_row   = rd_data;
                n_j     = '0;
                n_deg   = '0;
                if (diag) begin
                    n_out_valid = 1'b1;
                    n_verdict   = r_g ? gim_pkg::VERDICT_SECOND_NS : gim_pkg::VERDICT_FIRST_NS;
                end
            end
            gim_pkg::ST_SCAN: begin
                rd_addr = {r_g, r_j + VW'(1)};
                n_j     = r_j + VW'(1);
                n_deg   = deg_row;
                if (mismatch) begin
                    n_out_valid = 1'b1;
                    n_verdict   = r_g ? gim_pkg::VERDICT_SECOND_NS : gim_pkg::VERDICT_FIRST_NS;
                end else if (j_end) begin
                    deg_we = 1'b1;
                    if (r_g) n_e2 = r_e2 + EW'(deg_row);
                    else     n_e1 = r_e1 + EW'(deg_row);
                    if (i_end) begin
                        n_g = 1'b1;
                        n_i = '0;
                    end else begin
                        n_i = r_i + VW'(1);
                    end
                end
            end
            gim_pkg::ST_COUNTS: begin
                n_i    = '0;
                n_d    = '0;
                n_diff = '0;
                if (n1 != n2) begin
                    n_out_valid = 1'b1;
                    n_verdict   = gim_pkg::VERDICT_VCOUNT;
                end else if (r_e1 != r_e2) begin
                    n_out_valid = 1'b1;
                    n_verdict   = gim_pkg::VERDICT_EDGES;
                end
            end
            gim_pkg::ST_DEGREES: begin
                if (i_end) begin
                    n_i    = '0;
                    n_diff = '0;
                    n_d    = r_d + CW'(1);
                    if (diff_next != '0) begin
                        n_out_valid = 1'b1;
                        n_verdict   = gim_pkg::VERDICT_DEGREES;
                    end else if (r_d == n1) begin
                        n_out_valid = 1'b1;
                        n_verdict   = gim_pkg::VERDICT_MAYBE;
                    end
                end else begin
                    n_i    = r_i + VW'(1);
                    n_diff = diff_next;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gim_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_nv1       <= gim_pkg::CFG_W'(MAXV);
            r_nv2       <= gim_pkg::CFG_W'(MAXV);
            r_g         <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_d         <= '0;
            r_diff      <= '0;
            r_deg       <= '0;
            r_e1        <= '0;
            r_e2        <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_g         <= n_g;
            r_i         <= n_i;
            r_j         <= n_j;
            r_d         <= n_d;
            r_diff      <= n_diff;
            r_deg       <= n_deg;
            r_e1        <= n_e1;
            r_e2        <= n_e2;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SEL_FIRST:  r_nv1 <= i_cfg_data;
                    REG_SEL_SECOND: r_nv2 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_verdict <= n_verdict;
        if (deg_we) begin
            if (r_g) r_deg2[r_i] <= deg_row;
            else     r_deg1[r_i] <= deg_row;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = gim_pkg::M_DATA_W'(r_verdict);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a verdict is pending");

    a_start_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gim_pkg::ST_IDLE && s_tvalid && s_tready && s_tlast)
            |=> (r_state == gim_pkg::ST_RD_ROW))
        else $error("check did not start after the last transfer");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (r_verdict <= gim_pkg::VERDICT_DEGREES))
        else $error("verdict code out of range");

    a_verdict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_state == gim_pkg::ST_IDLE))
        else $error("verdict raised while the check is still running");
`endif

endmodule
